// File: hdl/nbt_pkg.sv
// Shared types and constants for the neighbor table tracker.
package nbt_pkg;

    localparam int DEF_TABLE_DEPTH = 16;
    localparam int DEF_BEACON_MIN_LENGTH = 14;
    localparam int ID_W = 48;
    localparam int TIME_W = 32;
    localparam int MAGIC_W = 16;
    localparam int LEN_W = 8;
    localparam int DBM_W = 8;
    localparam int OCC_W = 5;
    localparam int CFG_IDX_W = 8;

    localparam logic [TIME_W-1:0] RST_TIMEOUT = 32'd30000;
    localparam logic [MAGIC_W-1:0] RST_MAGIC = 16'h5453;

    localparam logic [CFG_IDX_W-1:0] REG_OWN_ID = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAGIC = 8'd2;

    typedef enum logic [2:0] {
        ST_SHORT = 3'd0,
        ST_BAD_MAGIC = 3'd1,
        ST_OWN_ID = 3'd2,
        ST_UPDATED = 3'd3,
        ST_ADDED = 3'd4,
        ST_FULL = 3'd5,
        ST_TIMED_OUT = 3'd6,
        ST_TICK_DONE = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        K_REJECT,
        K_BEACON,
        K_TICK
    } t_kind;

    typedef struct packed {
        logic [ID_W-1:0] own_id;
        logic [TIME_W-1:0] timeout;
        logic [MAGIC_W-1:0] magic;
    } t_cfg;

    typedef struct packed {
        t_kind kind;
        t_status status;
        logic [TIME_W-1:0] now_ms;
        logic [ID_W-1:0] sender_id;
        logic signed [DBM_W-1:0] signal_dbm;
    } t_job;

endpackage

// File: hdl/nbt_if.sv
// Channel interfaces of the neighbor table tracker.
interface nbt_in_if;
    logic valid;
    logic ready;
    logic operation;
    logic [nbt_pkg::TIME_W-1:0] now_ms;
    logic [nbt_pkg::LEN_W-1:0] beacon_length;
    logic [nbt_pkg::MAGIC_W-1:0] magic_word;
    logic [nbt_pkg::ID_W-1:0] sender_id;
    logic signed [nbt_pkg::DBM_W-1:0] signal_dbm;
    modport source (output valid, operation, now_ms, beacon_length, magic_word,
                    sender_id, signal_dbm, input ready);
    modport sink (input valid, operation, now_ms, beacon_length, magic_word,
                  sender_id, signal_dbm, output ready);
endinterface

interface nbt_out_if;
    logic valid;
    logic ready;
    logic [2:0] status;
    logic [nbt_pkg::ID_W-1:0] node_id;
    logic signed [nbt_pkg::DBM_W-1:0] mean_dbm;
    logic [nbt_pkg::OCC_W-1:0] occupancy;
    logic last;
    modport source (output valid, status, node_id, mean_dbm, occupancy, last,
                    input ready);
    modport sink (input valid, status, node_id, mean_dbm, occupancy, last,
                  output ready);
endinterface

interface nbt_cfg_if;
    logic valid;
    logic ready;
    logic [nbt_pkg::CFG_IDX_W-1:0] index;
    logic [nbt_pkg::ID_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/nbt_front.sv
// Front end: checks incoming beats and queues classified jobs.
module nbt_front #(
    parameter int BEACON_MIN_LENGTH = nbt_pkg::DEF_BEACON_MIN_LENGTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    nbt_in_if.sink         i_in,
    input  nbt_pkg::t_cfg  i_cfg,
    output logic           o_job_valid,
    input  logic           i_job_ready,
    output nbt_pkg::t_job  o_job
);
    localparam logic [nbt_pkg::LEN_W-1:0] MIN_LEN = nbt_pkg::LEN_W'(BEACON_MIN_LENGTH);

    nbt_pkg::t_job r_q [2];
    logic r_wr;
    logic r_rd;
    logic [1:0] r_cnt;
    nbt_pkg::t_job n_job;
    logic push;
    logic pop;

    always_comb begin
        n_job.now_ms = i_in.now_ms;
        n_job.sender_id = i_in.sender_id;
        n_job.signal_dbm = i_in.signal_dbm;
        n_job.kind = nbt_pkg::K_REJECT;
        n_job.status = nbt_pkg::ST_SHORT;
        if (i_in.operation) begin
            n_job.kind = nbt_pkg::K_TICK;
        end else if (i_in.beacon_length < MIN_LEN) begin
            n_job.status = nbt_pkg::ST_SHORT;
        end else if (i_in.magic_word != i_cfg.magic) begin
            n_job.status = nbt_pkg::ST_BAD_MAGIC;
        end else if (i_in.sender_id == i_cfg.own_id) begin
            n_job.status = nbt_pkg::ST_OWN_ID;
        end else begin
            n_job.kind = nbt_pkg::K_BEACON;
        end
    end

    assign i_in.ready = (r_cnt != 2'd2);
    assign push = i_in.valid && i_in.ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job = r_q[r_rd];
    assign pop = o_job_valid && i_job_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= n_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= 1'b0;
            r_rd <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end
endmodule

// File: hdl/nbt_back.sv
// Back end: neighbor table, search and timeout scan, result register.
module nbt_back #(
    parameter int TABLE_DEPTH = nbt_pkg::DEF_TABLE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  nbt_pkg::t_cfg  i_cfg,
    input  logic           i_job_valid,
    output logic           o_job_ready,
    input  nbt_pkg::t_job  i_job,
    nbt_out_if.source      o_out
);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SCAN
    } t_state;

    logic [nbt_pkg::ID_W-1:0] r_ids [TABLE_DEPTH];
    logic signed [nbt_pkg::DBM_W-1:0] r_last [TABLE_DEPTH];
    logic signed [nbt_pkg::DBM_W-1:0] r_mean [TABLE_DEPTH];
    logic [nbt_pkg::TIME_W-1:0] r_seen [TABLE_DEPTH];

    t_state r_state, n_state;
    nbt_pkg::t_job r_job, n_job;
    logic [CW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_count, n_count;

    logic r_out_valid, n_out_valid;
    nbt_pkg::t_status r_st, n_st;
    logic [nbt_pkg::ID_W-1:0] r_nid, n_nid;
    logic signed [nbt_pkg::DBM_W-1:0] r_om, n_om;
    logic [CW-1:0] r_occ, n_occ;
    logic r_fin, n_fin;

    logic free;
    logic emit;
    logic do_upd;
    logic do_app;
    logic do_rm;
    logic [CW-1:0] scan_pos;
    logic [IW-1:0] s_idx;
    logic [IW-1:0] c_idx;
    logic [IW-1:0] a_idx;
    logic signed [nbt_pkg::DBM_W:0] sum;
    logic signed [nbt_pkg::DBM_W:0] half;
    logic signed [nbt_pkg::DBM_W-1:0] new_mean;
    logic [nbt_pkg::TIME_W-1:0] age;

    assign free = !r_out_valid || o_out.ready;
    assign scan_pos = r_pos - CW'(1);
    assign s_idx = r_pos[IW-1:0];
    assign c_idx = scan_pos[IW-1:0];
    assign a_idx = r_count[IW-1:0];
    assign sum = (nbt_pkg::DBM_W+1)'(r_mean[s_idx]) + (nbt_pkg::DBM_W+1)'(r_job.signal_dbm);
    assign half = (sum + ((nbt_pkg::DBM_W+1)'(sum[nbt_pkg::DBM_W]))) >>> 1;
    assign new_mean = half[nbt_pkg::DBM_W-1:0];
    assign age = r_job.now_ms - r_seen[c_idx];

    always_comb begin
        n_state = r_state;
        n_job = r_job;
        n_pos = r_pos;
        n_count = r_count;
        o_job_ready = 1'b0;
        emit = 1'b0;
        do_upd = 1'b0;
        do_app = 1'b0;
        do_rm = 1'b0;
        n_st = nbt_pkg::ST_TICK_DONE;
        n_nid = '0;
        n_om = '0;
        n_fin = 1'b1;
        if (free) begin
            unique case (r_state)
                S_IDLE: begin
                    o_job_ready = 1'b1;
                    if (i_job_valid) begin
                        n_job = i_job;
                        unique case (i_job.kind)
                            nbt_pkg::K_BEACON: begin
                                n_state = S_SEARCH;
                                n_pos = '0;
                            end
                            nbt_pkg::K_TICK: begin
                                n_state = S_SCAN;
                                n_pos = r_count;
                            end
                            default: begin
                                emit = 1'b1;
                                n_st = i_job.status;
                            end
                        endcase
                    end
                end
                S_SEARCH: begin
                    if (r_pos == r_count) begin
                        emit = 1'b1;
                        n_state = S_IDLE;
                        if (r_count == FULL) begin
                            n_st = nbt_pkg::ST_FULL;
                        end else begin
                            do_app = 1'b1;
                            n_count = r_count + CW'(1);
                            n_st = nbt_pkg::ST_ADDED;
                            n_nid = r_job.sender_id;
                            n_om = r_job.signal_dbm;
                        end
                    end else if (r_ids[s_idx] == r_job.sender_id) begin
                        emit = 1'b1;
                        do_upd = 1'b1;
                        n_state = S_IDLE;
                        n_st = nbt_pkg::ST_UPDATED;
                        n_nid = r_job.sender_id;
                        n_om = new_mean;
                    end else begin
                        n_pos = r_pos + CW'(1);
                    end
                end
                S_SCAN: begin
                    if (r_pos == '0) begin
                        emit = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_pos = scan_pos;
                        if (age >= i_cfg.timeout) begin
                            emit = 1'b1;
                            do_rm = 1'b1;
                            n_count = r_count - CW'(1);
                            n_st = nbt_pkg::ST_TIMED_OUT;
                            n_nid = r_ids[c_idx];
                            n_fin = 1'b0;
                        end
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
        n_occ = n_count;
        n_out_valid = emit ? 1'b1 : (free ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (do_upd) begin
            r_seen[s_idx] <= r_job.now_ms;
            r_last[s_idx] <= r_job.signal_dbm;
            r_mean[s_idx] <= new_mean;
        end
        if (do_app) begin
            r_ids[a_idx] <= r_job.sender_id;
            r_seen[a_idx] <= r_job.now_ms;
            r_last[a_idx] <= r_job.signal_dbm;
            r_mean[a_idx] <= r_job.signal_dbm;
        end
        if (do_rm) begin
            for (int j = 0; j < TABLE_DEPTH - 1; j++) begin
                if ((CW'(j) >= scan_pos) && (CW'(j + 1) < r_count)) begin
                    r_ids[j] <= r_ids[j + 1];
                    r_seen[j] <= r_seen[j + 1];
                    r_last[j] <= r_last[j + 1];
                    r_mean[j] <= r_mean[j + 1];
                end
            end
        end
        if (emit) begin
            r_st <= n_st;
            r_nid <= n_nid;
            r_om <= n_om;
            r_occ <= n_occ;
            r_fin <= n_fin;
        end
        r_job <= n_job;
        r_pos <= n_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.status = r_st;
    assign o_out.node_id = r_nid;
    assign o_out.mean_dbm = r_om;
    assign o_out.occupancy = nbt_pkg::OCC_W'(r_occ);
    assign o_out.last = r_fin;
endmodule

// File: hdl/neighbor_table_tracker.sv
// Top level of the neighbor table tracker: configuration registers and wiring.
//
// Channel  Direction  Contents
// i_in     in         operation, now_ms, beacon_length, magic_word, sender_id, signal_dbm
// o_out    out        status, node_id, mean_dbm, occupancy, last
// i_cfg    in         register index and write data, always ready
//
// A beacon's result follows a search of the table entries in order, until a match or the end.
// A tick closes after a scan from the last entry down to the first; each removal is done in its scan step.
// A rejected beacon gives its result straight from the queue, with no search.
// The engine stays frozen while a result waits on o_out.
// The two-entry queue keeps accepting beats meanwhile and holds off i_in once it is full.
// Reset is synchronous and empties the table and queue at once.
module neighbor_table_tracker #(
    parameter int TABLE_DEPTH = nbt_pkg::DEF_TABLE_DEPTH,
    parameter int BEACON_MIN_LENGTH = nbt_pkg::DEF_BEACON_MIN_LENGTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    nbt_in_if.sink    i_in,
    nbt_out_if.source o_out,
    nbt_cfg_if.sink   i_cfg
);
    nbt_pkg::t_cfg r_cfg;
    logic job_valid;
    logic job_ready;
    nbt_pkg::t_job job;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_id <= '0;
            r_cfg.timeout <= nbt_pkg::RST_TIMEOUT;
            r_cfg.magic <= nbt_pkg::RST_MAGIC;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                nbt_pkg::REG_OWN_ID: r_cfg.own_id <= i_cfg.data;
                nbt_pkg::REG_TIMEOUT: r_cfg.timeout <= i_cfg.data[nbt_pkg::TIME_W-1:0];
                nbt_pkg::REG_MAGIC: r_cfg.magic <= i_cfg.data[nbt_pkg::MAGIC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    nbt_front #(
        .BEACON_MIN_LENGTH(BEACON_MIN_LENGTH)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(i_in),
        .i_cfg(r_cfg),
        .o_job_valid(job_valid),
        .i_job_ready(job_ready),
        .o_job(job)
    );

    nbt_back #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg(r_cfg),
        .i_job_valid(job_valid),
        .o_job_ready(job_ready),
        .i_job(job),
        .o_out(o_out)
    );
endmodule
